### hdl/ofn_pkg.sv
// Package for the orthonormal frame unit: payload structs, fixed-point types,
// per-lane state of the normalizer cells and the shared rounding helpers.
// No dependencies.
package ofn_pkg;

   // Fixed-point widths.
   localparam int COMP_W  = 16;   // component width, integer in and Q1.14 out
   localparam int QMAG_W  = 15;   // magnitude of a Q1.14 unit component
   localparam int SUM_W   = 32;   // sum of three squares
   localparam int RHS_W   = 61;   // |a|^2 * 2^30
   localparam int QD_W    = 50;   // running product (2q-1) * s
   localparam int CAND_W  = 67;   // candidate (2c-1)^2 * s, signed
   localparam int PROD_W  = 32;   // Q2.28 products
   localparam int RND_W   = 18;   // rounded Q1.14 before saturation
   localparam logic signed [COMP_W-1:0] ONE_Q14 = 16'sd16384;

   typedef logic signed [COMP_W-1:0] comp_type;
   typedef comp_type [2:0] vec3_type;

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   typedef struct packed {
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
      logic               last_in;
   } req_type;

   typedef struct packed {
      logic signed [15:0] tangent_x;
      logic signed [15:0] tangent_y;
      logic signed [15:0] tangent_z;
      logic signed [15:0] bitangent_x;
      logic signed [15:0] bitangent_y;
      logic signed [15:0] bitangent_z;
      logic signed [15:0] unit_normal_x;
      logic signed [15:0] unit_normal_y;
      logic signed [15:0] unit_normal_z;
      logic               last_out;
   } rsp_type;

   // One component's search state inside the normalizer chain.
   typedef struct packed {
      logic [RHS_W-1:0]        rhs;   // |a|^2 << 30
      logic [RHS_W-1:0]        p;     // (2q-1)^2 * s for the accepted q
      logic signed [QD_W-1:0]  qd;    // (2q-1) * s for the accepted q
      logic [QMAG_W-1:0]       q;     // magnitude found so far
      logic                    neg;   // sign of the input component
   } nrm_lane_type;

   typedef struct packed {
      nrm_lane_type [2:0]  lane;
      logic [SUM_W-1:0]    s;
   } nrm_state_type;

   // Round a Q2.28 value to Q1.14, halves away from zero.
   function automatic logic signed [RND_W-1:0] rnd_q14(input logic signed [PROD_W-1:0] v);
      logic [PROD_W-1:0] mag;
      logic [RND_W-1:0]  r;
      mag = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
      r   = RND_W'((mag + PROD_W'(8192)) >> 14);
      return v[PROD_W-1] ? -$signed(r) : $signed(r);
   endfunction

   // Absolute value of a Q1.14 or integer component, unsigned (-32768 gives 32768).
   function automatic logic [COMP_W-1:0] abs_q14(input comp_type v);
      return v[COMP_W-1] ? COMP_W'(-v) : COMP_W'(v);
   endfunction

endpackage

### hdl/ofn_nrm_cell.sv
// One cell of the normalizer chain: decides one magnitude bit for all three
// components and hands its state to the next cell. Depends on ofn_pkg.
module ofn_nrm_cell #(
   parameter int BIT    = 0,
   parameter int SIDE_W = 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   up_valid,
   input  ofn_pkg::nrm_state_type up_st,
   input  logic [SIDE_W-1:0]      up_side,
   output logic                   dn_valid,
   output ofn_pkg::nrm_state_type dn_st,
   output logic [SIDE_W-1:0]      dn_side
);
   import ofn_pkg::*;

   logic                valid_ff;
   nrm_state_type       st_ff, st_in;
   logic [SIDE_W-1:0]   side_ff;

   // Try setting this bit: (2c-1)^2 s grows from (2q-1)^2 s by shifted terms.
   always_comb begin
      logic signed [CAND_W-1:0] cand_p;
      logic                     take;
      st_in = up_st;
      for (int i = 0; i < 3; i++) begin
         cand_p = $signed({6'b0, up_st.lane[i].p})
                + ($signed({{(CAND_W-QD_W){up_st.lane[i].qd[QD_W-1]}}, up_st.lane[i].qd})
                   <<< (BIT + 2))
                + $signed({{(CAND_W-SUM_W){1'b0}}, up_st.s} << (2 * BIT + 2));
         take = !up_st.lane[i].q[QMAG_W-1]
              && (cand_p <= $signed({6'b0, up_st.lane[i].rhs}));
         if (take) begin
            st_in.lane[i].q  = up_st.lane[i].q | (QMAG_W'(1) << BIT);
            st_in.lane[i].p  = cand_p[RHS_W-1:0];
            st_in.lane[i].qd = up_st.lane[i].qd
                             + $signed({{(QD_W-SUM_W){1'b0}}, up_st.s} << (BIT + 1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff   <= st_in;
         side_ff <= up_side;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_st    = st_ff;
   assign dn_side  = side_ff;

endmodule

### hdl/ofn_normalize.sv
// Vector normalizer: squares and sum, a chain of fifteen bit cells, then sign
// and zero-vector handling. Result is Q1.14 rounded to nearest.
// Depends on ofn_pkg and ofn_nrm_cell.
module ofn_normalize #(
   parameter int SIDE_W = 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               up_valid,
   input  ofn_pkg::vec3_type  up_vec,
   input  logic [SIDE_W-1:0]  up_side,
   output logic               dn_valid,
   output ofn_pkg::vec3_type  dn_vec,
   output logic [SIDE_W-1:0]  dn_side
);
   import ofn_pkg::*;

   localparam int NCELL = QMAG_W;

   logic                    sq_valid_ff;
   logic [SUM_W-2:0]        sq_ff [3];
   logic [2:0]              neg_ff;
   logic [SIDE_W-1:0]       sq_side_ff;

   logic                    st_valid_ff;
   nrm_state_type           st_ff, st_in;
   logic [SIDE_W-1:0]       st_side_ff;

   logic                    ch_valid [NCELL+1];
   nrm_state_type           ch_st    [NCELL+1];
   logic [SIDE_W-1:0]       ch_side  [NCELL+1];

   logic                    out_valid_ff;
   vec3_type                out_vec_ff, out_vec_in;
   logic [SIDE_W-1:0]       out_side_ff;

   // Valid bits of the front and back stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff  <= 1'b0;
         st_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         sq_valid_ff  <= up_valid;
         st_valid_ff  <= sq_valid_ff;
         out_valid_ff <= ch_valid[NCELL];
      end
   end

   // Square each magnitude; a full-scale negative component squares to 2^30.
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            sq_ff[i]  <= (SUM_W-1)'(abs_q14(up_vec[i]) * abs_q14(up_vec[i]));
            neg_ff[i] <= up_vec[i][COMP_W-1];
         end
         sq_side_ff <= up_side;
      end
   end

   // Sum of squares and the starting state q = 0, i.e. 2q-1 = -1.
   always_comb begin
      logic [SUM_W-1:0] s;
      s = SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]);
      st_in.s = s;
      for (int i = 0; i < 3; i++) begin
         st_in.lane[i].rhs = {sq_ff[i][RHS_W-31:0], 30'b0};
         st_in.lane[i].p   = RHS_W'(s);
         st_in.lane[i].qd  = -$signed({{(QD_W-SUM_W){1'b0}}, s});
         st_in.lane[i].q   = '0;
         st_in.lane[i].neg = neg_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff      <= st_in;
         st_side_ff <= sq_side_ff;
      end
   end

   assign ch_valid[0] = st_valid_ff;
   assign ch_st[0]    = st_ff;
   assign ch_side[0]  = st_side_ff;

   // One cell per magnitude bit, most significant first.
   for (genvar j = 0; j < NCELL; j++) begin : g_cell
      ofn_nrm_cell #(
         .BIT    (NCELL - 1 - j),
         .SIDE_W (SIDE_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .up_valid (ch_valid[j]),
         .up_st    (ch_st[j]),
         .up_side  (ch_side[j]),
         .dn_valid (ch_valid[j+1]),
         .dn_st    (ch_st[j+1]),
         .dn_side  (ch_side[j+1])
      );
   end

   // Apply signs; a zero vector maps to the z axis.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         out_vec_in[i] = ch_st[NCELL].lane[i].neg
                       ? -$signed({1'b0, ch_st[NCELL].lane[i].q})
                       :  $signed({1'b0, ch_st[NCELL].lane[i].q});
      end
      if (ch_st[NCELL].s == '0) begin
         out_vec_in[0] = '0;
         out_vec_in[1] = '0;
         out_vec_in[2] = ONE_Q14;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_vec_ff  <= out_vec_in;
         out_side_ff <= ch_side[NCELL];
      end
   end

   assign dn_valid = out_valid_ff;
   assign dn_vec   = out_vec_ff;
   assign dn_side  = out_side_ff;

endmodule

### hdl/orthonormal_frame_from_normal_unit.sv
// Orthonormal frame unit: one transaction accepted per cycle while req_stall
// is low, that is while the skid buffer is empty; results leave on rsp.
// Latency is set mostly by the two chains of fifteen normalizer cells; each
// decides one magnitude bit per cycle for all three components unless held.
// A one-entry skid buffer behind the output register holds the pipeline.
// Synchronous active-high reset clears all valid bits; no data is cleared.
module orthonormal_frame_from_normal_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ofn_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ofn_pkg::rsp_type rsp_data
);
   import ofn_pkg::*;

   localparam int SIDE2_W = 3 * COMP_W + 1;

   logic                 adv;
   vec3_type             in_vec;

   logic                 n_valid;
   vec3_type             n_vec;
   logic                 n_last;

   logic                 a1_valid_ff;
   vec3_type             a1_n_ff;
   logic                 a1_last_ff;
   axis_type             a1_k_ff, a1_k_in;

   logic                 a2_valid_ff;
   vec3_type             a2_n_ff;
   logic                 a2_last_ff;
   axis_type             a2_k_ff;
   logic signed [PROD_W-1:0] a2_prod_ff [3];
   comp_type             nk;

   logic                 a3_valid_ff;
   vec3_type             a3_t_ff, a3_t_in;
   logic [SIDE2_W-1:0]   a3_side_ff;

   logic                 x_valid;
   vec3_type             x_vec;
   logic [SIDE2_W-1:0]   x_side;

   logic                 c1_valid_ff;
   vec3_type             c1_x_ff, c1_n_ff;
   logic                 c1_last_ff;
   logic signed [PROD_W-1:0] c1_pa_ff [3];
   logic signed [PROD_W-1:0] c1_pb_ff [3];

   logic                 c2_valid_ff;
   rsp_type              c2_data_ff, c2_data_in;

   logic                 rsp_valid_ff;
   rsp_type              rsp_data_ff;
   logic                 skid_valid_ff;
   rsp_type              skid_data_ff;

   // The whole pipeline moves unless the skid buffer holds a transaction.
   assign adv       = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   assign in_vec[0] = req_data.normal_x;
   assign in_vec[1] = req_data.normal_y;
   assign in_vec[2] = req_data.normal_z;

   // Unit normal.
   ofn_normalize #(
      .SIDE_W (1)
   ) u_nrm_normal (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .up_valid (req_valid && !req_stall),
      .up_vec   (in_vec),
      .up_side  (req_data.last_in),
      .dn_valid (n_valid),
      .dn_vec   (n_vec),
      .dn_side  (n_last)
   );

   // Least-aligned axis; x wins ties, then y.
   always_comb begin
      logic [COMP_W-1:0] ax, ay, az;
      ax = abs_q14(n_vec[0]);
      ay = abs_q14(n_vec[1]);
      az = abs_q14(n_vec[2]);
      priority if (ax <= ay && ax <= az) begin
         a1_k_in = AXIS_X;
      end else if (ay <= az) begin
         a1_k_in = AXIS_Y;
      end else begin
         a1_k_in = AXIS_Z;
      end
   end

   // Selected component of the normal.
   always_comb begin
      unique case (a1_k_ff)
         AXIS_X:  nk = a1_n_ff[0];
         AXIS_Y:  nk = a1_n_ff[1];
         AXIS_Z:  nk = a1_n_ff[2];
         default: nk = a1_n_ff[0];
      endcase
   end

   // Projection of the axis onto the plane, rounded to Q1.14.
   always_comb begin
      logic signed [PROD_W-1:0] p;
      logic signed [RND_W-1:0]  r;
      for (int i = 0; i < 3; i++) begin
         p = (a2_k_ff == axis_type'(i)) ? (PROD_W'(1) <<< 28) : '0;
         p = p - a2_prod_ff[i];
         r = rnd_q14(p);
         a3_t_in[i] = r[COMP_W-1:0];
      end
   end

   // Valid bits of the frame stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         a1_valid_ff <= 1'b0;
         a2_valid_ff <= 1'b0;
         a3_valid_ff <= 1'b0;
         c1_valid_ff <= 1'b0;
         c2_valid_ff <= 1'b0;
      end else if (adv) begin
         a1_valid_ff <= n_valid;
         a2_valid_ff <= a1_valid_ff;
         a3_valid_ff <= a2_valid_ff;
         c1_valid_ff <= x_valid;
         c2_valid_ff <= c1_valid_ff;
      end
   end

   // Axis pick, products n_k * n_i and projection.
   always_ff @(posedge clock) begin
      if (adv) begin
         a1_n_ff    <= n_vec;
         a1_last_ff <= n_last;
         a1_k_ff    <= a1_k_in;
         a2_n_ff    <= a1_n_ff;
         a2_last_ff <= a1_last_ff;
         a2_k_ff    <= a1_k_ff;
         for (int i = 0; i < 3; i++) begin
            a2_prod_ff[i] <= PROD_W'(nk * a1_n_ff[i]);
         end
         a3_t_ff    <= a3_t_in;
         a3_side_ff <= {a2_last_ff, a2_n_ff};
      end
   end

   // Tangent: the projected axis normalized.
   ofn_normalize #(
      .SIDE_W (SIDE2_W)
   ) u_nrm_tangent (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .up_valid (a3_valid_ff),
      .up_vec   (a3_t_ff),
      .up_side  (a3_side_ff),
      .dn_valid (x_valid),
      .dn_vec   (x_vec),
      .dn_side  (x_side)
   );

   // Cross product partial terms.
   always_ff @(posedge clock) begin
      vec3_type n;
      n = x_side[3*COMP_W-1:0];
      if (adv) begin
         c1_x_ff    <= x_vec;
         c1_n_ff    <= n;
         c1_last_ff <= x_side[SIDE2_W-1];
         c1_pa_ff[0] <= PROD_W'(n[1] * x_vec[2]);
         c1_pb_ff[0] <= PROD_W'(n[2] * x_vec[1]);
         c1_pa_ff[1] <= PROD_W'(n[2] * x_vec[0]);
         c1_pb_ff[1] <= PROD_W'(n[0] * x_vec[2]);
         c1_pa_ff[2] <= PROD_W'(n[0] * x_vec[1]);
         c1_pb_ff[2] <= PROD_W'(n[1] * x_vec[0]);
      end
   end

   // Bitangent rounded and clamped to one; assemble the result.
   always_comb begin
      logic signed [RND_W-1:0] r;
      comp_type                y [3];
      for (int i = 0; i < 3; i++) begin
         r = rnd_q14(c1_pa_ff[i] - c1_pb_ff[i]);
         if (r > RND_W'(ONE_Q14)) begin
            y[i] = ONE_Q14;
         end else if (r < -RND_W'(ONE_Q14)) begin
            y[i] = -ONE_Q14;
         end else begin
            y[i] = r[COMP_W-1:0];
         end
      end
      c2_data_in.tangent_x     = c1_x_ff[0];
      c2_data_in.tangent_y     = c1_x_ff[1];
      c2_data_in.tangent_z     = c1_x_ff[2];
      c2_data_in.bitangent_x   = y[0];
      c2_data_in.bitangent_y   = y[1];
      c2_data_in.bitangent_z   = y[2];
      c2_data_in.unit_normal_x = c1_n_ff[0];
      c2_data_in.unit_normal_y = c1_n_ff[1];
      c2_data_in.unit_normal_z = c1_n_ff[2];
      c2_data_in.last_out      = c1_last_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c2_data_ff <= c2_data_in;
      end
   end

   // Output register with a skid entry behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (!rsp_valid_ff || !rsp_stall) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (!rsp_valid_ff || !rsp_stall) begin
         rsp_valid_ff <= c2_valid_ff;
      end else if (c2_valid_ff) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (!rsp_valid_ff || !rsp_stall) begin
            rsp_data_ff <= skid_data_ff;
         end
      end else if (!rsp_valid_ff || !rsp_stall) begin
         rsp_data_ff <= c2_data_ff;
      end else begin
         skid_data_ff <= c2_data_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The skid entry only fills while the output transaction is held.
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp_valid_ff && rsp_stall))
      else $error("skid entry filled without a stalled output");

   // A buffered transaction always sits behind a valid output.
   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry valid while output register empty");

   // The x and z bitangent components stay within one after clamping.
   a_bitan_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.bitangent_x <= ONE_Q14
                        && rsp_data_ff.bitangent_x >= -ONE_Q14
                        && rsp_data_ff.bitangent_z <= ONE_Q14
                        && rsp_data_ff.bitangent_z >= -ONE_Q14))
      else $error("bitangent component out of range");

endmodule
